// File: design/btmx_pkg.sv
package btmx_pkg;

   localparam int KEY_BITS   = 31;
   localparam int NODE_POOL  = 65536;
   localparam int COUNT_BITS = 20;

   localparam int NODE_BITS  = $clog2(NODE_POOL);
   localparam int LEVEL_BITS = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int NEED_BITS  = $clog2(KEY_BITS + 1);
   localparam int FREE_BITS  = $clog2(NODE_POOL + 1);

   typedef logic [KEY_BITS-1:0]        key_type;
   typedef logic [NODE_BITS-1:0]       node_type;
   typedef logic [1:0][NODE_BITS-1:0]  links_type;
   typedef logic [COUNT_BITS-1:0]      count_type;
   typedef logic [LEVEL_BITS-1:0]      level_type;
   typedef logic [NEED_BITS-1:0]       need_type;
   typedef logic [FREE_BITS-1:0]       free_type;

   localparam count_type CNT_MAX   = '1;
   localparam level_type TOP_LEVEL = level_type'(KEY_BITS - 1);

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ABSENT    = 2'd1,
      STATUS_POOL_FULL = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic      wr_en;
      node_type  wr_addr;
      links_type wr_data;
      node_type  rd_addr;
   } link_req_type;

   typedef struct packed {
      logic      wr_en;
      node_type  wr_addr;
      count_type wr_data;
      node_type  rd_addr_a;
      node_type  rd_addr_b;
   } cnt_req_type;

endpackage

// File: design/binary_trie_max_xor.sv
// Channel    Ports                                  Beat taken when
// request    start, busy, req_mode, req_value       start high and busy low
// response   rsp_valid, rsp_max_xor, rsp_status     rsp_valid high (one cycle)
//
// Query: reads the root links from a register, then one link read and one paired
// count read per trie level below the root. Delete: check pass, then update
// pass, one level per cycle. Insert: check pass, update pass, parent link write,
// then the new nodes written one by one down to level zero. Unused mode: status OK.
// Reset clears the root links and sets the free pointer to node 1; node memories need no
// clearing pass. The response cannot be stalled; busy stays low while it shows.
module binary_trie_max_xor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [btmx_pkg::KEY_BITS-1:0]   req_value,
   output logic                            rsp_valid,
   output logic [btmx_pkg::KEY_BITS-1:0]   rsp_max_xor,
   output logic [1:0]                      rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_WALK,
      S_PARENT,
      S_ALLOC,
      S_Q_LINK,
      S_Q_CNT
   } state_type;

   state_type               state_ff, state_in;
   btmx_pkg::mode_type      mode_ff, mode_in;
   logic                    pass_ff, pass_in;
   btmx_pkg::key_type       key_ff, key_in;
   btmx_pkg::level_type     lvl_ff, lvl_in;
   btmx_pkg::node_type      node_ff, node_in;
   btmx_pkg::node_type      par_ff, par_in;
   logic                    par_root_ff, par_root_in;
   btmx_pkg::links_type     par_links_ff, par_links_in;
   btmx_pkg::links_type     root_ff, root_in;
   btmx_pkg::links_type     kids_ff, kids_in;
   logic                    over_ff, over_in;
   btmx_pkg::level_type     alloc_ff, alloc_in;
   btmx_pkg::free_type      free_ff, free_in;
   btmx_pkg::key_type       acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   btmx_pkg::key_type       rsp_max_xor_ff, rsp_max_xor_in;
   btmx_pkg::status_type    rsp_status_ff, rsp_status_in;

   btmx_pkg::link_req_type  link_req;
   btmx_pkg::links_type     link_rd;
   btmx_pkg::cnt_req_type   cnt_req;
   btmx_pkg::count_type     cnt_rd_a;
   btmx_pkg::count_type     cnt_rd_b;

   logic                    brk;
   btmx_pkg::level_type     brk_lvl;
   logic                    walk_end;
   logic                    restart;
   logic                    fin;
   btmx_pkg::status_type    fin_status;
   btmx_pkg::key_type       fin_xor;
   logic                    over_now;
   btmx_pkg::node_type      nxt;
   btmx_pkg::level_type     lvl_dn;
   btmx_pkg::need_type      need;
   btmx_pkg::free_type      room;
   btmx_pkg::links_type     plinks;
   btmx_pkg::links_type     new_links;
   logic [1:0]              live;
   logic                    kb;
   logic                    go;
   btmx_pkg::key_type       acc_now;

   btmx_link_ram u_link_ram (
      .clock   (clock),
      .req     (link_req),
      .rd_data (link_rd)
   );

   btmx_cnt_ram u_cnt_ram (
      .clock     (clock),
      .req       (cnt_req),
      .rd_data_a (cnt_rd_a),
      .rd_data_b (cnt_rd_b)
   );

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_xor = rsp_max_xor_ff;
   assign rsp_status  = rsp_status_ff;

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      pass_in        = pass_ff;
      key_in         = key_ff;
      lvl_in         = lvl_ff;
      node_in        = node_ff;
      par_in         = par_ff;
      par_root_in    = par_root_ff;
      par_links_in   = par_links_ff;
      root_in        = root_ff;
      kids_in        = kids_ff;
      over_in        = over_ff;
      alloc_in       = alloc_ff;
      free_in        = free_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = 1'b0;
      rsp_max_xor_in = rsp_max_xor_ff;
      rsp_status_in  = rsp_status_ff;

      link_req   = '0;
      cnt_req    = '0;
      brk        = 1'b0;
      brk_lvl    = '0;
      walk_end   = 1'b0;
      restart    = 1'b0;
      fin        = 1'b0;
      fin_status = btmx_pkg::STATUS_OK;
      fin_xor    = '0;
      over_now   = over_ff;
      nxt        = '0;
      lvl_dn     = lvl_ff - btmx_pkg::level_type'(1);
      need       = '0;
      room       = btmx_pkg::free_type'(btmx_pkg::NODE_POOL) - free_ff;
      plinks     = par_links_ff;
      new_links  = '0;
      live       = '0;
      kb         = key_ff[lvl_ff];
      go         = 1'b0;
      acc_now    = acc_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = btmx_pkg::mode_type'(req_mode);
               key_in   = req_value;
               pass_in  = 1'b0;
               over_in  = 1'b0;
               acc_in   = '0;
               state_in = S_START;
            end
         end

         S_START: begin
            lvl_in       = btmx_pkg::TOP_LEVEL;
            par_root_in  = 1'b1;
            par_links_in = root_ff;
            case (mode_ff)
               btmx_pkg::MODE_INSERT, btmx_pkg::MODE_DELETE: begin
                  nxt = root_ff[key_ff[btmx_pkg::TOP_LEVEL]];
                  if (nxt == '0) begin
                     brk     = 1'b1;
                     brk_lvl = btmx_pkg::TOP_LEVEL;
                  end else begin
                     link_req.rd_addr  = nxt;
                     cnt_req.rd_addr_a = nxt;
                     node_in           = nxt;
                     state_in          = S_WALK;
                  end
               end
               btmx_pkg::MODE_QUERY: begin
                  kids_in           = root_ff;
                  cnt_req.rd_addr_a = root_ff[0];
                  cnt_req.rd_addr_b = root_ff[1];
                  state_in          = S_Q_CNT;
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end

         S_WALK: begin
            over_now = over_ff | (cnt_rd_a >= btmx_pkg::CNT_MAX);
            if (pass_ff) begin
               cnt_req.wr_en   = 1'b1;
               cnt_req.wr_addr = node_ff;
               cnt_req.wr_data = (mode_ff == btmx_pkg::MODE_INSERT)
                                 ? cnt_rd_a + btmx_pkg::count_type'(1)
                                 : cnt_rd_a - btmx_pkg::count_type'(1);
            end
            if (mode_ff == btmx_pkg::MODE_DELETE && !pass_ff && cnt_rd_a == '0) begin
               fin        = 1'b1;
               fin_status = btmx_pkg::STATUS_ABSENT;
            end else if (lvl_ff == '0) begin
               walk_end = 1'b1;
            end else begin
               nxt          = link_rd[key_ff[lvl_dn]];
               par_in       = node_ff;
               par_root_in  = 1'b0;
               par_links_in = link_rd;
               over_in      = over_now;
               if (nxt == '0) begin
                  brk     = 1'b1;
                  brk_lvl = lvl_dn;
               end else begin
                  link_req.rd_addr  = nxt;
                  cnt_req.rd_addr_a = nxt;
                  node_in           = nxt;
                  lvl_in            = lvl_dn;
               end
            end
         end

         S_PARENT: begin
            plinks[key_ff[alloc_ff]] = btmx_pkg::node_type'(free_ff);
            if (par_root_ff) begin
               root_in = plinks;
            end else begin
               link_req.wr_en   = 1'b1;
               link_req.wr_addr = par_ff;
               link_req.wr_data = plinks;
            end
            lvl_in   = alloc_ff;
            state_in = S_ALLOC;
         end

         S_ALLOC: begin
            // chain each new node to the next one below it
            if (lvl_ff != '0) begin
               new_links[key_ff[lvl_dn]] =
                  btmx_pkg::node_type'(free_ff + btmx_pkg::free_type'(1));
            end
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = btmx_pkg::node_type'(free_ff);
            link_req.wr_data = new_links;
            cnt_req.wr_en    = 1'b1;
            cnt_req.wr_addr  = btmx_pkg::node_type'(free_ff);
            cnt_req.wr_data  = btmx_pkg::count_type'(1);
            free_in          = free_ff + btmx_pkg::free_type'(1);
            if (lvl_ff == '0) begin
               fin = 1'b1;
            end else begin
               lvl_in = lvl_dn;
            end
         end

         S_Q_LINK: begin
            kids_in           = link_rd;
            cnt_req.rd_addr_a = link_rd[0];
            cnt_req.rd_addr_b = link_rd[1];
            state_in          = S_Q_CNT;
         end

         S_Q_CNT: begin
            live[0] = (kids_ff[0] != '0) && (cnt_rd_a != '0);
            live[1] = (kids_ff[1] != '0) && (cnt_rd_b != '0);
            // prefer the child opposite to the key bit
            if (live[~kb]) begin
               acc_now[lvl_ff] = 1'b1;
               nxt             = kids_ff[~kb];
               go              = 1'b1;
            end else if (live[kb]) begin
               nxt = kids_ff[kb];
               go  = 1'b1;
            end
            acc_in = acc_now;
            if (!go || lvl_ff == '0) begin
               fin     = 1'b1;
               fin_xor = (acc_now > key_ff) ? acc_now : key_ff;
            end else begin
               link_req.rd_addr = nxt;
               lvl_in           = lvl_dn;
               state_in         = S_Q_LINK;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (brk) begin
         need = btmx_pkg::need_type'(brk_lvl) + btmx_pkg::need_type'(1);
         if (mode_ff == btmx_pkg::MODE_INSERT) begin
            if (!pass_ff) begin
               if (over_now) begin
                  fin        = 1'b1;
                  fin_status = btmx_pkg::STATUS_OVERFLOW;
               end else if (btmx_pkg::free_type'(need) > room) begin
                  fin        = 1'b1;
                  fin_status = btmx_pkg::STATUS_POOL_FULL;
               end else begin
                  restart = 1'b1;
               end
            end else begin
               alloc_in = brk_lvl;
               state_in = S_PARENT;
            end
         end else begin
            fin        = 1'b1;
            fin_status = btmx_pkg::STATUS_ABSENT;
         end
      end

      if (walk_end) begin
         if (pass_ff) begin
            fin = 1'b1;
         end else if (mode_ff == btmx_pkg::MODE_INSERT && over_now) begin
            fin        = 1'b1;
            fin_status = btmx_pkg::STATUS_OVERFLOW;
         end else begin
            restart = 1'b1;
         end
      end

      if (restart) begin
         pass_in  = 1'b1;
         over_in  = 1'b0;
         state_in = S_START;
      end

      if (fin) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = fin_status;
         rsp_max_xor_in = fin_xor;
         state_in       = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_ff      <= btmx_pkg::free_type'(1);
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      pass_ff        <= pass_in;
      key_ff         <= key_in;
      lvl_ff         <= lvl_in;
      node_ff        <= node_in;
      par_ff         <= par_in;
      par_root_ff    <= par_root_in;
      par_links_ff   <= par_links_in;
      kids_ff        <= kids_in;
      over_ff        <= over_in;
      alloc_ff       <= alloc_in;
      acc_ff         <= acc_in;
      rsp_max_xor_ff <= rsp_max_xor_in;
      rsp_status_ff  <= rsp_status_in;
   end

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_alloc_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |->
         (free_ff < btmx_pkg::free_type'(btmx_pkg::NODE_POOL)))
      else $error("node allocated beyond the pool");

   a_xor_only_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode_ff != btmx_pkg::MODE_QUERY) |-> (rsp_max_xor == '0))
      else $error("nonzero xor on a non-query result");

endmodule

// File: design/btmx_link_ram.sv
module btmx_link_ram (
   input  logic                  clock,
   input  btmx_pkg::link_req_type req,
   output btmx_pkg::links_type    rd_data
);

   btmx_pkg::links_type mem [btmx_pkg::NODE_POOL];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data <= mem[req.rd_addr];
   end

endmodule

// File: design/btmx_cnt_ram.sv
module btmx_cnt_ram (
   input  logic                 clock,
   input  btmx_pkg::cnt_req_type req,
   output btmx_pkg::count_type   rd_data_a,
   output btmx_pkg::count_type   rd_data_b
);

   btmx_pkg::count_type mem [btmx_pkg::NODE_POOL];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_a <= mem[req.rd_addr_a];
      rd_data_b <= mem[req.rd_addr_b];
   end

endmodule

// File: bench/binary_trie_max_xor_tb.sv
`timescale 1ns / 1ps

module binary_trie_max_xor_tb;

   localparam logic [1:0]        MODE_UNUSED  = 2'd3;
   localparam int                CYCLE_LIMIT  = 1_000_000;
   localparam int                RANDOM_OPS   = 1275;
   localparam int                TAIL_CYCLES  = 150;
   localparam btmx_pkg::key_type KEY_ALL_ONES = '1;
   localparam btmx_pkg::key_type KEY_TOP_BIT  =
      btmx_pkg::key_type'(1 << (btmx_pkg::KEY_BITS - 1));

   typedef struct packed {
      btmx_pkg::key_type    max_xor;
      btmx_pkg::status_type status;
   } answer_type;

   typedef struct packed {
      logic       pinned;
      answer_type answer;
   } issue_note_type;

   typedef struct packed {
      logic [1:0]        mode;
      btmx_pkg::key_type value;
      logic              pinned;
      answer_type        answer;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_mode = btmx_pkg::MODE_INSERT;
   btmx_pkg::key_type req_value = '0;
   logic              rsp_valid;
   btmx_pkg::key_type rsp_max_xor;
   logic [1:0]        rsp_status;

   // Shadow trie: node 0 is the root, link 0 means no child.
   bit [btmx_pkg::NODE_BITS-1:0]  trie_links [btmx_pkg::NODE_POOL][2];
   bit [btmx_pkg::COUNT_BITS-1:0] trie_counts [btmx_pkg::NODE_POOL];
   int                            trie_next_free = 1;

   answer_type        pending_answers [$];
   issue_note_type    issued_notes [$];
   btmx_pkg::key_type kept_values [$];
   directed_row_type  directed_rows [$];

   answer_type     due_answer;
   answer_type     trie_answer;
   issue_note_type beat_note;
   int             error_total = 0;
   int             cycle_count = 0;
   int             burst_left = 0;

   binary_trie_max_xor DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_mode    (req_mode),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_max_xor (rsp_max_xor),
      .rsp_status  (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic btmx_pkg::status_type trie_insert(btmx_pkg::key_type v);
      int n;
      int c;
      int need;
      int lv;
      bit over;
      bit b;
      n = 0;
      need = 0;
      over = 1'b0;
      for (lv = btmx_pkg::KEY_BITS; lv >= 1; lv--) begin
         c = trie_links[n][v[lv-1]];
         if (c == 0) begin
            need = lv;
            break;
         end
         if (trie_counts[c] == btmx_pkg::CNT_MAX) over = 1'b1;
         n = c;
      end
      // overflow wins over a full pool
      if (over) return btmx_pkg::STATUS_OVERFLOW;
      if (need > btmx_pkg::NODE_POOL - trie_next_free) return btmx_pkg::STATUS_POOL_FULL;
      n = 0;
      for (lv = btmx_pkg::KEY_BITS; lv >= 1; lv--) begin
         b = v[lv-1];
         c = trie_links[n][b];
         if (c == 0) begin
            c = trie_next_free;
            trie_next_free++;
            trie_links[c][0] = '0;
            trie_links[c][1] = '0;
            trie_counts[c] = '0;
            trie_links[n][b] = c[btmx_pkg::NODE_BITS-1:0];
         end
         trie_counts[c] = trie_counts[c] + 1'b1;
         n = c;
      end
      return btmx_pkg::STATUS_OK;
   endfunction

   function automatic btmx_pkg::status_type trie_delete(btmx_pkg::key_type v);
      int n;
      int c;
      int lv;
      n = 0;
      for (lv = btmx_pkg::KEY_BITS; lv >= 1; lv--) begin
         c = trie_links[n][v[lv-1]];
         if (c == 0 || trie_counts[c] == 0) return btmx_pkg::STATUS_ABSENT;
         n = c;
      end
      n = 0;
      for (lv = btmx_pkg::KEY_BITS; lv >= 1; lv--) begin
         c = trie_links[n][v[lv-1]];
         trie_counts[c] = trie_counts[c] - 1'b1;
         n = c;
      end
      return btmx_pkg::STATUS_OK;
   endfunction

   function automatic btmx_pkg::key_type trie_best_xor(btmx_pkg::key_type v);
      int                n;
      int                c;
      int                lv;
      bit                b;
      btmx_pkg::key_type acc;
      n = 0;
      acc = '0;
      for (lv = btmx_pkg::KEY_BITS; lv >= 1; lv--) begin
         b = v[lv-1];
         c = trie_links[n][b ^ 1'b1];
         if (c != 0 && trie_counts[c] != 0) begin
            acc[lv-1] = 1'b1;
            n = c;
         end else begin
            c = trie_links[n][b];
            // dead end: leave the low bits at zero
            if (c == 0 || trie_counts[c] == 0) break;
            n = c;
         end
      end
      // zero is always a member, so the key itself is a floor
      return (acc > v) ? acc : v;
   endfunction

   function automatic answer_type trie_apply(logic [1:0] mode, btmx_pkg::key_type v);
      answer_type a;
      a.max_xor = '0;
      a.status = btmx_pkg::STATUS_OK;
      case (mode)
         btmx_pkg::MODE_INSERT: a.status = trie_insert(v);
         btmx_pkg::MODE_DELETE: a.status = trie_delete(v);
         btmx_pkg::MODE_QUERY:  a.max_xor = trie_best_xor(v);
         default:               ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Check the response before logging a new beat: both can land on one edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
               $error("unexpected response: max_xor %h status %0d",
                      rsp_max_xor, rsp_status);
               error_total++;
            end else begin
               due_answer = pending_answers.pop_front();
               if (rsp_max_xor !== due_answer.max_xor) begin
                  $error("max_xor: expected %h, actual %h", due_answer.max_xor, rsp_max_xor);
                  error_total++;
               end
               if (rsp_status !== due_answer.status) begin
                  $error("status: expected %0d, actual %0d", due_answer.status, rsp_status);
                  error_total++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            beat_note = issued_notes.pop_front();
            trie_answer = trie_apply(req_mode, req_value);
            if (beat_note.pinned) trie_answer = beat_note.answer;
            pending_answers = {pending_answers, trie_answer};
         end
      end
   end

   task automatic issue_op(input logic [1:0] mode, input btmx_pkg::key_type v,
                           input logic pinned = 1'b0,
                           input btmx_pkg::key_type pin_xor = '0,
                           input btmx_pkg::status_type pin_status = btmx_pkg::STATUS_OK);
      issue_note_type n;
      n.pinned = pinned;
      n.answer.max_xor = pin_xor;
      n.answer.status = pin_status;
      issued_notes = {issued_notes, n};
      start <= 1'b1;
      req_mode <= mode;
      req_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 60);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic btmx_pkg::key_type kept_pick();
      if (kept_values.size() == 0) return btmx_pkg::key_type'($urandom);
      return kept_values[$urandom_range(0, kept_values.size() - 1)];
   endfunction

   function automatic btmx_pkg::key_type any_key();
      case ($urandom_range(0, 5))
         0, 1:    return btmx_pkg::key_type'($urandom);
         2:       return btmx_pkg::key_type'($urandom_range(0, 255));
         3:       return ~btmx_pkg::key_type'($urandom_range(0, 255));
         4:       return kept_pick() ^ btmx_pkg::key_type'($urandom_range(0, 15));
         default: return kept_pick();
      endcase
   endfunction

   task automatic random_op();
      int                pick;
      btmx_pkg::key_type v;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         v = any_key();
         kept_values = {kept_values, v};
         issue_op(btmx_pkg::MODE_INSERT, v);
      end else if (pick < 65) begin
         v = ($urandom_range(0, 4) != 0) ? kept_pick() : any_key();
         issue_op(btmx_pkg::MODE_DELETE, v);
      end else if (pick < 95) begin
         issue_op(btmx_pkg::MODE_QUERY, any_key());
      end else begin
         issue_op(MODE_UNUSED, btmx_pkg::key_type'($urandom));
      end
      pace_sender();
   endtask

   task automatic add_row(input logic [1:0] mode, input btmx_pkg::key_type v,
                          input logic pinned, input btmx_pkg::key_type pin_xor,
                          input btmx_pkg::status_type pin_status);
      directed_row_type r;
      r.mode = mode;
      r.value = v;
      r.pinned = pinned;
      r.answer.max_xor = pin_xor;
      r.answer.status = pin_status;
      directed_rows = {directed_rows, r};
   endtask

   initial begin
      directed_row_type r;

      // empty store answers with the key itself
      add_row(btmx_pkg::MODE_QUERY,  '0,           1'b1, '0,           btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_QUERY,  KEY_ALL_ONES, 1'b1, KEY_ALL_ONES, btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_DELETE, '0,           1'b1, '0,           btmx_pkg::STATUS_ABSENT);
      add_row(MODE_UNUSED,           KEY_ALL_ONES, 1'b1, '0,           btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_INSERT, '0,           1'b1, '0,           btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_INSERT, KEY_ALL_ONES, 1'b1, '0,           btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_QUERY,  '0,           1'b1, KEY_ALL_ONES, btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_QUERY,  KEY_ALL_ONES, 1'b1, KEY_ALL_ONES, btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_INSERT, KEY_TOP_BIT,  1'b1, '0,           btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_QUERY,  ~KEY_TOP_BIT, 1'b0, '0,           btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_INSERT, 31'h5555_5555, 1'b1, '0,          btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_INSERT, 31'h5555_5555, 1'b1, '0,          btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_QUERY,  31'h2AAA_AAAA, 1'b0, '0,          btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_DELETE, 31'h5555_5555, 1'b1, '0,          btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_DELETE, 31'h5555_5555, 1'b1, '0,          btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_DELETE, 31'h5555_5555, 1'b1, '0,          btmx_pkg::STATUS_ABSENT);
      add_row(btmx_pkg::MODE_QUERY,  31'h2AAA_AAAA, 1'b0, '0,          btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_DELETE, KEY_ALL_ONES - btmx_pkg::key_type'(1), 1'b1, '0,
              btmx_pkg::STATUS_ABSENT);
      add_row(btmx_pkg::MODE_DELETE, KEY_ALL_ONES, 1'b1, '0,           btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_DELETE, '0,           1'b1, '0,           btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_DELETE, KEY_TOP_BIT,  1'b1, '0,           btmx_pkg::STATUS_OK);
      // all counts drained: walk stops at the root
      add_row(btmx_pkg::MODE_QUERY,  31'h1234_5678, 1'b1, 31'h1234_5678, btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_INSERT, 31'h0000_0001, 1'b1, '0,          btmx_pkg::STATUS_OK);
      add_row(btmx_pkg::MODE_QUERY,  '0,           1'b0, '0,           btmx_pkg::STATUS_OK);
      add_row(MODE_UNUSED,           '0,           1'b1, '0,           btmx_pkg::STATUS_OK);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         issue_op(r.mode, r.value, r.pinned, r.answer.max_xor, r.answer.status);
         pace_sender();
      end

      for (int i = 0; i < RANDOM_OPS; i++) begin
         // hold the sender once until every answer is back
         if (i == RANDOM_OPS / 2) drain_results();
         random_op();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_total == 0 && pending_answers.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
